// ===== hw/rtl/stdp_pkg.sv =====
package stdp_pkg;

  localparam int TIME_W = 24;
  localparam int COND_W = 32;
  localparam int AMP_W  = 16;
  localparam int KERN_W = 32;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Kernel index: |tau| in 1/8 ms steps, times are Q16.8
  localparam int STEP_SHIFT = 5;
  localparam int IDX_W = TIME_W - STEP_SHIFT;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CONDUCTANCE  = 2'd1;

  localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd256;
  localparam logic [COND_W-1:0] COND_RESET = 32'd0;

  // Kernel table build constants: e in Q2.32, e^(-1/80) in Q0.32, scale in Q0.40
  localparam logic [63:0] E_Q32  = 64'd11674931555;
  localparam logic [63:0] EM_Q32 = 64'd4241614355;
  localparam logic [63:0] CK_Q40 = 64'd2565772385;
  localparam logic [63:0] H_DIV  = 64'd80;

  typedef struct packed {
    logic              pre_started_spiking;
    logic              post_started_spiking;
    logic [TIME_W-1:0] pre_spike_time;
    logic [TIME_W-1:0] post_spike_time;
  } in_req_t;

  typedef struct packed {
    logic [COND_W-1:0] conductance;
    logic              weight_changed;
  } out_res_t;

  typedef struct packed {
    logic pair;
    logic positive;
    logic in_range;
  } stdp_ctl_t;

endpackage

// ===== hw/rtl/stdp_ram.sv =====
module stdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/stdp_upd.sv =====
module stdp_upd #(
  parameter int FRAC_BITS = 24
) (
  input  stdp_pkg::stdp_ctl_t        ctl,
  input  logic [stdp_pkg::COND_W-1:0] cond,
  input  logic                        changed,
  input  logic [stdp_pkg::AMP_W-1:0]  amp,
  input  logic [stdp_pkg::KERN_W-1:0] kern,
  output logic [stdp_pkg::COND_W-1:0] cond_nxt,
  output logic                        changed_nxt
);
  import stdp_pkg::*;

  localparam int PROD_W = AMP_W + KERN_W;
  localparam int SHIFT  = PROD_W - FRAC_BITS;
  localparam int MAG_W  = PROD_W - SHIFT;

  logic [KERN_W-1:0] kern_sel;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  mag;
  logic [COND_W-1:0] mag_ext;
  logic [COND_W:0]   sum;
  logic [COND_W-1:0] pot;
  logic [COND_W-1:0] dep;

  // Kernel is zero beyond the table
  assign kern_sel = ctl.in_range ? kern : '0;
  assign prod     = PROD_W'(amp) * PROD_W'(kern_sel);
  assign mag      = prod[PROD_W-1:SHIFT];
  assign mag_ext  = COND_W'(mag);
  assign sum      = {1'b0, cond} + {1'b0, mag_ext};
  assign pot      = sum[COND_W] ? '1 : sum[COND_W-1:0];
  assign dep      = (cond > mag_ext) ? (cond - mag_ext) : '0;

  always_comb begin
    cond_nxt    = cond;
    changed_nxt = changed;
    if (ctl.pair) begin
      if (mag == '0) begin
        changed_nxt = 1'b0;
      end else begin
        changed_nxt = 1'b1;
        cond_nxt    = ctl.positive ? pot : dep;
      end
    end
  end

endmodule

// ===== hw/rtl/stdp_synapse_weight_update_unit.sv =====
// STDP weight update for one synapse.
// Input channel (in_valid/in_ready/in_data) takes one simulation event per
// request: spike onset flags and the last pre/post spike times (Q16.8 ms).
// Result channel (out_valid/out_ready/out_data) returns one result per
// request: the conductance after the event (Q8.24) and the changed flag.
// Configuration: cfg_we/cfg_index/cfg_wdata write learning_amplitude (0) or
// start_conductance (1); writing start_conductance also loads the stored
// conductance. Other indexes are ignored. Write only while the block is idle.
// Timing: a request is read from the kernel RAM at the edge that accepts it; the
// update and result register load when the update stage can advance (result
// register empty or out_ready high), and out_valid rises with that load.
// With the kernel loaded and out_ready high, one request per cycle is sustained:
// the kernel RAM read port and the single update stage each handle one event per cycle.
// Reset: conductance returns to 0, amplitude to 1.0, changed flag clears.
// The kernel table is then copied into RAM, one entry per cycle, with in_ready
// low until the copy ends. Configuration writes are taken then.
// Receiver stall: the result register holds; one more request can be taken
// into the update stage, after which in_ready drops until out_ready returns.
module stdp_synapse_weight_update_unit #(
  parameter int KERNEL_DEPTH          = 512,
  parameter int CONDUCTANCE_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  stdp_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output stdp_pkg::out_res_t             out_data,
  input  logic                           cfg_we,
  input  logic [stdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stdp_pkg::CFG_W-1:0]     cfg_wdata
);
  import stdp_pkg::*;

  localparam int AW = $clog2(KERNEL_DEPTH);

  typedef logic [KERNEL_DEPTH-1:0][KERN_W-1:0] kern_tbl_t;

  function automatic logic [63:0] qmul32(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'h8000_0000) >> 32;
  endfunction

  // h = u*e^(1-u), u = t/10; kernel = C*h^10
  function automatic kern_tbl_t build_kernel();
    kern_tbl_t   tbl;
    logic [63:0] p;
    logic [63:0] h;
    logic [63:0] h2;
    logic [63:0] h4;
    logic [63:0] h8;
    logic [63:0] h10;
    p = E_Q32;
    for (int i = 0; i < KERNEL_DEPTH; i++) begin
      if (i > 0) begin
        p = qmul32(p, EM_Q32);
      end
      h = (p * 64'(i)) / H_DIV;
      if (h > 64'hFFFF_FFFF) begin
        h = 64'hFFFF_FFFF;
      end
      h2  = qmul32(h, h);
      h4  = qmul32(h2, h2);
      h8  = qmul32(h4, h4);
      h10 = qmul32(h8, h2);
      tbl[i] = KERN_W'(qmul32(CK_Q40, h10));
    end
    return tbl;
  endfunction

  localparam kern_tbl_t KERN_TBL = build_kernel();

  // Kernel load after reset
  logic [AW-1:0] fill_addr_r;
  logic [AW-1:0] fill_addr_nxt;
  logic          fill_done_r;
  logic          fill_done_nxt;

  logic [AMP_W-1:0]  amp_r;
  logic [COND_W-1:0] cond_r;
  logic              chg_r;

  logic      s1_vld_r;
  stdp_ctl_t s1_ctl_r;
  stdp_ctl_t in_ctl;
  logic      s1_go;
  logic      in_accept;

  logic      out_vld_r;
  out_res_t  out_data_r;

  logic [TIME_W-1:0] abs_diff;
  logic [IDX_W-1:0]  kern_idx;
  logic [KERN_W-1:0] kern_rd;
  logic [COND_W-1:0] cond_nxt;
  logic              chg_nxt;

  assign fill_done_nxt = fill_done_r || (fill_addr_r == AW'(KERNEL_DEPTH - 1));
  assign fill_addr_nxt = fill_done_r ? fill_addr_r : fill_addr_r + AW'(1);

  always_comb begin
    in_ctl.pair = (in_data.pre_started_spiking || in_data.post_started_spiking)
                  && (in_data.pre_spike_time != '0) && (in_data.post_spike_time != '0);
    in_ctl.positive = in_data.post_spike_time > in_data.pre_spike_time;
    abs_diff = in_ctl.positive ? (in_data.post_spike_time - in_data.pre_spike_time)
                               : (in_data.pre_spike_time - in_data.post_spike_time);
    kern_idx = abs_diff[TIME_W-1:STEP_SHIFT];
    in_ctl.in_range = kern_idx < IDX_W'(KERNEL_DEPTH);
  end

  assign s1_go     = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = fill_done_r && (!s1_vld_r || s1_go);
  assign in_accept = in_valid && in_ready;

  stdp_ram #(
    .WIDTH (KERN_W),
    .DEPTH (KERNEL_DEPTH)
  ) u_kern_ram (
    .clk     (clk),
    .wr_en   (!fill_done_r),
    .wr_addr (fill_addr_r),
    .wr_data (KERN_TBL[fill_addr_r]),
    .rd_en   (in_accept),
    .rd_addr (kern_idx[AW-1:0]),
    .rd_data (kern_rd)
  );

  stdp_upd #(
    .FRAC_BITS (CONDUCTANCE_FRAC_BITS)
  ) u_upd (
    .ctl         (s1_ctl_r),
    .cond        (cond_r),
    .changed     (chg_r),
    .amp         (amp_r),
    .kern        (kern_rd),
    .cond_nxt    (cond_nxt),
    .changed_nxt (chg_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_addr_r  <= '0;
      fill_done_r  <= 1'b0;
      amp_r        <= AMP_RESET;
      cond_r       <= COND_RESET;
      chg_r        <= 1'b0;
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      fill_addr_r <= fill_addr_nxt;
      fill_done_r <= fill_done_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEARNING_AMPLITUDE: amp_r <= cfg_wdata[AMP_W-1:0];
          CFG_START_CONDUCTANCE: begin
            cond_r <= cfg_wdata[COND_W-1:0];
          end
          default: ;
        endcase
      end else if (s1_go) begin
        cond_r <= cond_nxt;
        chg_r  <= chg_nxt;
      end

      if (in_accept) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end

      if (s1_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctl_r <= in_ctl;
    end
    if (s1_go) begin
      out_data_r.conductance    <= cond_nxt;
      out_data_r.weight_changed <= chg_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
